// ===== hw/rtl/eeprom_checksum_mac_loader_assert.svh =====
// assertion macros for the eeprom checksum and mac loader
`ifndef EEPROM_CHECKSUM_MAC_LOADER_ASSERT_SVH
`define EEPROM_CHECKSUM_MAC_LOADER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ECML_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ECML_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ecml_pkg.sv =====
package ecml_pkg;

  // opcodes of an input word
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  // kinds of a result word
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // load status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_SIG  = 2'd1;
  localparam logic [1:0] STATUS_BAD_SUM  = 2'd2;

  // signature check on word 0
  localparam logic [15:0] SIG_MASK  = 16'h00c0;
  localparam logic [15:0] SIG_VALUE = 16'h0040;

  // checksum pass
  localparam logic [15:0] CHECKSUM_TARGET = 16'hbaba;
  localparam logic [15:0] SUM_WORDS       = 16'h0040;
  localparam logic [17:0] ADDR_LIMIT      = 18'h0ffff;

  // pointer words
  localparam logic [3:0]  PTR_FIRST  = 4'h3;
  localparam logic [3:0]  PTR_END    = 4'hf;
  localparam logic [15:0] MAC_PTR_LO = 16'd9;
  localparam logic [15:0] MAC_PTR_HI = 16'd10;

  // mac words after the mac pointer
  localparam logic [1:0] MAC_WORDS = 2'd3;

endpackage

// ===== hw/rtl/eeprom_checksum_mac_loader.sv =====
// EEPROM checksum and MAC loader. A start word while idle begins a load; the block answers each
// accepted word with at most one result word: a read request for the next EEPROM
// word, or a finished word with the status and, when ok, the MAC address. Feed
// each returned EEPROM word back as a data word. It checks the signature of word
// 0, sums words 0..63 and the sections behind pointer words 3..14 to 0xBABA, then
// reads three words behind pointer word 9 or 10 into the MAC address and adds
// lane_bits to its last byte. One word is taken per clock: each word passes
// through one next-state stage into the result register, and item_stall is high
// only while that register holds a result that the far side stalls. lane_bits must be
// written by the user through lane_write and lane_data while no load is running (not enforced).
module eeprom_checksum_mac_loader (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        lane_write,
  input  logic [1:0]  lane_data,
  // item channel
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        opcode,
  input  logic [15:0] word_data,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic        kind,
  output logic [15:0] read_address,
  output logic [1:0]  load_status,
  output logic [47:0] mac_address
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_SIG,
    PH_SUM,
    PH_PTR,
    PH_LEN,
    PH_SECT,
    PH_MACPTR,
    PH_MAC
  } phase_t;

  logic [1:0]  lane_bits;
  phase_t      phase, phase_next;
  logic [15:0] running_sum, running_sum_next;
  logic [15:0] word_index, word_index_next;
  logic [3:0]  pointer_slot, pointer_slot_next;
  logic [16:0] section_end, section_end_next;
  logic [15:0] mac_base, mac_base_next;
  logic [47:0] mac_bytes, mac_bytes_next;
  logic [1:0]  mac_word_count, mac_word_count_next;

  logic        accept;
  logic        emit;
  logic        emit_kind;
  logic [15:0] emit_addr;
  logic [1:0]  emit_status;
  logic [47:0] emit_mac;
  logic        take_next;

  // shared arithmetic
  logic [15:0] word_inc;
  logic [15:0] sum_add;
  logic [17:0] len_total;
  logic [3:0]  slot_inc;
  logic [15:0] np_sum;
  logic [1:0]  mac_k;
  logic [1:0]  mac_count_inc;
  logic [47:0] mac_merged;
  logic [7:0]  mac_last;

  // handshake: take a word unless a result word is stuck
  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  assign word_inc  = word_index + 16'd1;
  assign sum_add   = running_sum + word_data;
  assign len_total = {2'b00, word_index} + {2'b00, word_data} + 18'd1;
  assign slot_inc  = pointer_slot + 4'd1;
  assign np_sum    = (phase == PH_SECT) ? sum_add : running_sum;

  // mac word placement
  assign mac_k         = (mac_word_count > 2'd2) ? 2'd2 : mac_word_count;
  assign mac_count_inc = mac_k + 2'd1;
  always_comb begin
    case (mac_k)
      2'd0:    mac_merged = mac_bytes | {32'h0, word_data};
      2'd1:    mac_merged = mac_bytes | {16'h0, word_data, 16'h0};
      default: mac_merged = mac_bytes | {word_data, 32'h0};
    endcase
  end
  assign mac_last = mac_merged[47:40] + {6'b0, lane_bits};

  // next state and result
  always_comb begin
    phase_next          = phase;
    running_sum_next    = running_sum;
    word_index_next     = word_index;
    pointer_slot_next   = pointer_slot;
    section_end_next    = section_end;
    mac_base_next       = mac_base;
    mac_bytes_next      = mac_bytes;
    mac_word_count_next = mac_word_count;
    emit        = 1'b0;
    emit_kind   = ecml_pkg::KIND_READ;
    emit_addr   = 16'h0;
    emit_status = ecml_pkg::STATUS_OK;
    emit_mac    = 48'h0;
    take_next   = 1'b0;

    if (accept) begin
      if (opcode == ecml_pkg::OP_START) begin
        if (phase == PH_IDLE) begin
          running_sum_next    = 16'h0;
          word_index_next     = 16'h0;
          pointer_slot_next   = ecml_pkg::PTR_FIRST;
          section_end_next    = 17'h0;
          mac_base_next       = 16'h0;
          mac_bytes_next      = 48'h0;
          mac_word_count_next = 2'd0;
          phase_next          = PH_SIG;
          emit                = 1'b1;
          emit_addr           = 16'h0;
        end
      end else begin
        case (phase)
          PH_SIG: begin
            emit = 1'b1;
            if ((word_data & ecml_pkg::SIG_MASK) != ecml_pkg::SIG_VALUE) begin
              emit_kind   = ecml_pkg::KIND_DONE;
              emit_status = ecml_pkg::STATUS_BAD_SIG;
              phase_next  = PH_IDLE;
            end else begin
              running_sum_next = word_data;
              word_index_next  = 16'd1;
              phase_next       = PH_SUM;
              emit_addr        = 16'd1;
            end
          end
          PH_SUM: begin
            running_sum_next = sum_add;
            word_index_next  = word_inc;
            emit             = 1'b1;
            if (word_inc < ecml_pkg::SUM_WORDS) begin
              emit_addr = word_inc;
            end else begin
              pointer_slot_next = ecml_pkg::PTR_FIRST;
              phase_next        = PH_PTR;
              emit_addr         = {12'h0, ecml_pkg::PTR_FIRST};
            end
          end
          PH_PTR: begin
            word_index_next = word_data + 16'd1;
            phase_next      = PH_LEN;
            emit            = 1'b1;
            emit_addr       = word_data;
          end
          PH_LEN: begin
            if (len_total > ecml_pkg::ADDR_LIMIT || word_data == 16'h0) begin
              take_next = 1'b1;
            end else begin
              section_end_next = len_total[16:0] - 17'd1;
              phase_next       = PH_SECT;
              emit             = 1'b1;
              emit_addr        = word_index;
            end
          end
          PH_SECT: begin
            running_sum_next = sum_add;
            word_index_next  = word_inc;
            if ({1'b0, word_inc} < section_end) begin
              emit      = 1'b1;
              emit_addr = word_inc;
            end else begin
              take_next = 1'b1;
            end
          end
          PH_MACPTR: begin
            mac_base_next       = word_data + 16'd1;
            mac_word_count_next = 2'd0;
            mac_bytes_next      = 48'h0;
            phase_next          = PH_MAC;
            emit                = 1'b1;
            emit_addr           = word_data + 16'd1;
          end
          PH_MAC: begin
            mac_bytes_next      = mac_merged;
            mac_word_count_next = mac_count_inc;
            emit                = 1'b1;
            if (mac_count_inc < ecml_pkg::MAC_WORDS) begin
              emit_addr = mac_base + {14'h0, mac_count_inc};
            end else begin
              mac_bytes_next = {mac_last, mac_merged[39:0]};
              emit_kind      = ecml_pkg::KIND_DONE;
              emit_mac       = {mac_last, mac_merged[39:0]};
              phase_next     = PH_IDLE;
            end
          end
          default: begin
            // data word while idle is dropped
          end
        endcase

        // step to the next pointer word or close the checksum pass
        if (take_next) begin
          pointer_slot_next = slot_inc;
          emit              = 1'b1;
          if (slot_inc < ecml_pkg::PTR_END) begin
            phase_next = PH_PTR;
            emit_addr  = {12'h0, slot_inc};
          end else if (np_sum != ecml_pkg::CHECKSUM_TARGET) begin
            emit_kind   = ecml_pkg::KIND_DONE;
            emit_status = ecml_pkg::STATUS_BAD_SUM;
            phase_next  = PH_IDLE;
          end else begin
            phase_next = PH_MACPTR;
            emit_addr  = lane_bits[1] ? ecml_pkg::MAC_PTR_HI : ecml_pkg::MAC_PTR_LO;
          end
        end
      end
    end
  end

  // state, configuration and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      lane_bits      <= 2'd0;
      phase          <= PH_IDLE;
      running_sum    <= 16'h0;
      word_index     <= 16'h0;
      pointer_slot   <= ecml_pkg::PTR_FIRST;
      section_end    <= 17'h0;
      mac_base       <= 16'h0;
      mac_bytes      <= 48'h0;
      mac_word_count <= 2'd0;
      result_valid   <= 1'b0;
    end else begin
      if (lane_write) begin
        lane_bits <= lane_data;
      end
      phase          <= phase_next;
      running_sum    <= running_sum_next;
      word_index     <= word_index_next;
      pointer_slot   <= pointer_slot_next;
      section_end    <= section_end_next;
      mac_base       <= mac_base_next;
      mac_bytes      <= mac_bytes_next;
      mac_word_count <= mac_word_count_next;
      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      kind         <= emit_kind;
      read_address <= emit_addr;
      load_status  <= emit_status;
      mac_address  <= emit_mac;
    end
  end

`include "eeprom_checksum_mac_loader_assert.svh"

  `ECML_IMPLIES(a_done_addr_zero, result_valid && kind == ecml_pkg::KIND_DONE, read_address == 16'h0, "finished word carries a read address")
  `ECML_IMPLIES(a_fail_mac_zero, result_valid && load_status != ecml_pkg::STATUS_OK, mac_address == 48'h0, "failed load carries a mac address")
  `ECML_NEXT(a_start_reads_zero, accept && opcode == ecml_pkg::OP_START && phase == PH_IDLE, result_valid && kind == ecml_pkg::KIND_READ && read_address == 16'h0, "start did not request word 0")
  `ECML_IMPLIES(a_read_status_ok, result_valid && kind == ecml_pkg::KIND_READ, load_status == ecml_pkg::STATUS_OK && mac_address == 48'h0, "read request carries status")

endmodule
